>>> src/was_pkg.sv
package was_pkg;

  localparam int DEF_ENTRIES = 8;

  // command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_PROG = 1'b1;

  // entry status codes
  localparam logic [1:0] ST_OFF     = 2'd0;
  localparam logic [1:0] ST_ARMED   = 2'd1;
  localparam logic [1:0] ST_RUNNING = 2'd2;

  // action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_END   = 1'b1;

  localparam logic [5:0] HALF_MINUTE = 6'd30;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] start_hour;
    logic [5:0] start_minute;
    logic [4:0] end_hour;
    logic [5:0] end_minute;
    logic [6:0] weekdays;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic tick_load;
    logic prog_wr;
    logic rd_en;
    logic flush;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_rd;
  } dp_stat_t;

endpackage

>>> src/weekday_alarm_scheduler.sv
// Weekday alarm scheduler. Pulse start while busy is low to issue one
// transaction: cmd program writes one table entry in that cycle and busy
// stays low; cmd tick scans the table one entry per cycle through a simple
// dual-port table RAM and holds busy high through the scan, drain and flush
// states. Each fired action appears on strobe for exactly one cycle and must
// be taken then; there is no way to stall it. The final result of a tick,
// marked by last, arrives after the drain and flush states that follow
// the last read, so a tick with results ends no later than busy falls.
module weekday_alarm_scheduler #(
  parameter int ENTRIES = was_pkg::DEF_ENTRIES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       end_action_mask_we,
  input  logic [7:0] end_action_mask,
  input  logic       cmd,
  input  logic [2:0] entry,
  input  logic [4:0] start_hour,
  input  logic [5:0] start_minute,
  input  logic [4:0] end_hour,
  input  logic [5:0] end_minute,
  input  logic [6:0] weekday_mask,
  input  logic [1:0] set_status,
  input  logic [4:0] now_hour,
  input  logic [5:0] now_minute,
  input  logic [5:0] now_second,
  input  logic [2:0] now_weekday,
  output logic       strobe,
  output logic [2:0] entry_index,
  output logic       action,
  output logic [1:0] new_status,
  output logic       last
);

  import was_pkg::*;

  ctrl_cmd_t ctl;
  dp_stat_t  stat;

  was_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .cmd  (cmd),
    .stat (stat),
    .busy (busy),
    .ctl  (ctl)
  );

  was_dp #(
    .ENTRIES(ENTRIES)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .ctl               (ctl),
    .stat              (stat),
    .end_action_mask_we(end_action_mask_we),
    .end_action_mask   (end_action_mask),
    .entry             (entry),
    .start_hour        (start_hour),
    .start_minute      (start_minute),
    .end_hour          (end_hour),
    .end_minute        (end_minute),
    .weekday_mask      (weekday_mask),
    .set_status        (set_status),
    .now_hour          (now_hour),
    .now_minute        (now_minute),
    .now_second        (now_second),
    .now_weekday       (now_weekday),
    .strobe            (strobe),
    .entry_index       (entry_index),
    .action            (action),
    .new_status        (new_status),
    .last              (last)
  );

endmodule

>>> src/was_ram.sv
module was_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/was_ctrl.sv
module was_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               cmd,
  input  was_pkg::dp_stat_t  stat,
  output logic               busy,
  output was_pkg::ctrl_cmd_t ctl
);

  import was_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start && cmd == CMD_TICK) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.last_rd) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_FLUSH;
      S_FLUSH: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy          = 1'b1;
    ctl.tick_load = 1'b0;
    ctl.prog_wr   = 1'b0;
    ctl.rd_en     = 1'b0;
    ctl.flush     = 1'b0;
    case (state)
      S_IDLE: begin
        busy          = 1'b0;
        ctl.tick_load = start && cmd == CMD_TICK;
        ctl.prog_wr   = start && cmd == CMD_PROG;
      end
      S_SCAN:  ctl.rd_en = 1'b1;
      S_DRAIN: ;
      S_FLUSH: ctl.flush = 1'b1;
      default: ;
    endcase
  end

endmodule

>>> src/was_dp.sv
module was_dp #(
  parameter int ENTRIES = was_pkg::DEF_ENTRIES
) (
  input  logic               clk,
  input  logic               rst,
  input  was_pkg::ctrl_cmd_t ctl,
  output was_pkg::dp_stat_t  stat,
  input  logic               end_action_mask_we,
  input  logic [7:0]         end_action_mask,
  input  logic [2:0]         entry,
  input  logic [4:0]         start_hour,
  input  logic [5:0]         start_minute,
  input  logic [4:0]         end_hour,
  input  logic [5:0]         end_minute,
  input  logic [6:0]         weekday_mask,
  input  logic [1:0]         set_status,
  input  logic [4:0]         now_hour,
  input  logic [5:0]         now_minute,
  input  logic [5:0]         now_second,
  input  logic [2:0]         now_weekday,
  output logic               strobe,
  output logic [2:0]         entry_index,
  output logic               action,
  output logic [1:0]         new_status
  ,
  output logic               last
);

  import was_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int IW = (AW > 3) ? AW : 3;

  logic [7:0]         end_mask;
  logic [ENTRIES-1:0] vld;
  logic [AW-1:0]      cnt;
  logic               ev;
  logic [AW-1:0]      ev_idx;
  logic               ev_vld;
  logic [4:0]         hr;
  logic [5:0]         mn;
  logic [5:0]         sc;
  logic [2:0]         wd;

  logic               pend_vld;
  logic [2:0]         pend_idx;
  logic               pend_act;
  logic [1:0]         pend_st;

  entry_t             rdata;
  entry_t             prog_word;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  entry_t             ram_wdata;
  logic [AW-1:0]      prog_addr;
  logic               prog_ok;

  logic [IW-1:0]      ev_wide;
  logic               has_end;
  logic [6:0]         daybit;
  logic               day_ok;
  logic               at_start;
  logic               at_end;
  logic [1:0]         after_st;
  logic [1:0]         st1;
  logic               fire;
  logic               fire_act;
  logic               hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      end_mask <= '0;
    end else if (end_action_mask_we) begin
      end_mask <= end_action_mask;
    end
  end

  assign prog_ok   = 7'(entry) < 7'(ENTRIES);
  assign prog_addr = AW'(entry);

  always_comb begin
    prog_word.status       = (set_status == 2'd3) ? ST_OFF : set_status;
    prog_word.start_hour   = start_hour;
    prog_word.start_minute = start_minute;
    prog_word.end_hour     = end_hour;
    prog_word.end_minute   = end_minute;
    prog_word.weekdays     = weekday_mask;
  end

  // entries never programmed since reset stay invalid, so they never fire
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ctl.prog_wr && prog_ok) begin
      vld[prog_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev <= 1'b0;
    end else begin
      ev <= ctl.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.tick_load) begin
      cnt <= '0;
      hr  <= now_hour;
      mn  <= now_minute;
      sc  <= now_second;
      wd  <= now_weekday;
    end else if (ctl.rd_en) begin
      cnt <= cnt + AW'(1);
    end
    if (ctl.rd_en) begin
      ev_idx <= cnt;
      ev_vld <= vld[cnt];
    end
  end

  assign stat.last_rd = ctl.rd_en && cnt == AW'(ENTRIES - 1);

  // evaluate the entry read in the previous cycle
  always_comb begin
    ev_wide  = IW'(ev_idx);
    has_end  = (ev_wide >> 3) == '0 && end_mask[ev_wide[2:0]];
    daybit   = (wd < 3'd7) ? (7'd1 << wd) : 7'd0;
    day_ok   = (rdata.weekdays & daybit) != 7'd0 || rdata.weekdays == 7'd0;
    at_start = rdata.start_hour == hr && rdata.start_minute == mn;
    at_end   = rdata.end_hour == hr && rdata.end_minute == mn;
    after_st = (rdata.weekdays != 7'd0) ? ST_ARMED : ST_OFF;
    st1      = rdata.status;
    fire     = 1'b0;
    fire_act = ACT_START;
    if (st1 == ST_ARMED && day_ok && at_start && sc < HALF_MINUTE) begin
      st1  = ST_RUNNING;
      fire = 1'b1;
    end
    if (st1 == ST_RUNNING) begin
      if (has_end) begin
        if (at_end && sc > HALF_MINUTE) begin
          st1      = after_st;
          fire     = 1'b1;
          fire_act = ACT_END;
        end
      end else if (at_start && sc > HALF_MINUTE) begin
        st1 = after_st;
      end
    end
  end

  assign hit = ev && ev_vld && fire;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ev_idx;
    ram_wdata = rdata;
    if (ctl.prog_wr) begin
      ram_we    = prog_ok;
      ram_waddr = prog_addr;
      ram_wdata = prog_word;
    end else if (ev && ev_vld && st1 != rdata.status) begin
      ram_we           = 1'b1;
      ram_wdata.status = st1;
    end
  end

  was_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(cnt),
    .rdata(rdata)
  );

  // hold one result back so the final one of a tick can carry last
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_vld <= 1'b0;
    end else if (ctl.tick_load || ctl.flush) begin
      pend_vld <= 1'b0;
    end else if (hit) begin
      pend_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      pend_idx <= ev_wide[2:0];
      pend_act <= fire_act;
      pend_st  <= st1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= pend_vld && (hit || ctl.flush);
    end
  end

  always_ff @(posedge clk) begin
    entry_index <= pend_idx;
    action      <= pend_act;
    new_status  <= pend_st;
    last        <= ctl.flush;
  end

  a_no_wr_clash: assert property (@(posedge clk) disable iff (rst)
    !(ctl.prog_wr && ev))
    else $error("program write during scan");

  a_ev_follows_rd: assert property (@(posedge clk) disable iff (rst)
    ev |-> $past(ctl.rd_en))
    else $error("evaluation without a read");

  a_last_on_flush: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> $past(ctl.flush))
    else $error("last result outside flush");

  a_pend_clear: assert property (@(posedge clk) disable iff (rst)
    ctl.flush |=> !pend_vld)
    else $error("pending result survives flush");

endmodule

>>> verif/weekday_alarm_scheduler_tb.sv
package was_tb_pkg;
  import was_pkg::*;

  localparam logic [1:0] ST_UNUSED     = 2'd3;
  localparam logic [2:0] DAYS_PER_WEEK = 3'd7;

  typedef struct packed {
    logic       cmd;
    logic [2:0] entry;
    logic [4:0] start_hour;
    logic [5:0] start_minute;
    logic [4:0] end_hour;
    logic [5:0] end_minute;
    logic [6:0] weekday_mask;
    logic [1:0] set_status;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
    logic [5:0] now_second;
    logic [2:0] now_weekday;
  } alarm_cmd_t;

  typedef struct packed {
    logic [2:0] idx;
    logic       act;
    logic [1:0] status;
    logic       last;
  } fired_action_t;

  class alarm_scoreboard;
    entry_t          slots[DEF_ENTRIES];
    logic [7:0]      end_mask;
    fired_action_t   due_actions[$];
    int              errors;
    int              checked;
    int              ticks;
    int              progs;

    function new();
      foreach (slots[i]) slots[i] = '0;
      end_mask = '0;
      errors   = 0;
      checked  = 0;
      ticks    = 0;
      progs    = 0;
    endfunction

    function void set_end_mask(logic [7:0] value);
      end_mask = value;
    endfunction

    function logic [1:0] rest_status(int i);
      return (slots[i].weekdays != '0) ? ST_ARMED : ST_OFF;
    endfunction

    // Update the table copy and queue the actions this transaction fires.
    function void note_command(alarm_cmd_t c);
      fired_action_t hits[$];
      fired_action_t hit;
      logic [6:0]    day_bit;
      logic          at_start;
      logic          fired;
      if (c.cmd == CMD_PROG) begin
        progs++;
        slots[c.entry].status       = (c.set_status == ST_UNUSED) ? ST_OFF : c.set_status;
        slots[c.entry].start_hour   = c.start_hour;
        slots[c.entry].start_minute = c.start_minute;
        slots[c.entry].end_hour     = c.end_hour;
        slots[c.entry].end_minute   = c.end_minute;
        slots[c.entry].weekdays     = c.weekday_mask;
        return;
      end
      ticks++;
      day_bit = (c.now_weekday < DAYS_PER_WEEK) ? (7'd1 << c.now_weekday) : '0;
      for (int i = 0; i < DEF_ENTRIES; i++) begin
        at_start = slots[i].start_hour == c.now_hour && slots[i].start_minute == c.now_minute;
        fired    = 1'b0;
        hit      = '0;
        if (slots[i].status == ST_ARMED &&
            ((slots[i].weekdays & day_bit) != '0 || slots[i].weekdays == '0) &&
            at_start && c.now_second < HALF_MINUTE) begin
          slots[i].status = ST_RUNNING;
          fired           = 1'b1;
          hit.act         = ACT_START;
        end
        if (slots[i].status == ST_RUNNING) begin
          if (end_mask[i]) begin
            if (slots[i].end_hour == c.now_hour && slots[i].end_minute == c.now_minute &&
                c.now_second > HALF_MINUTE) begin
              slots[i].status = rest_status(i);
              fired           = 1'b1;
              hit.act         = ACT_END;
            end
          end else if (at_start && c.now_second > HALF_MINUTE) begin
            // no end action: drop back silently after the start minute
            slots[i].status = rest_status(i);
          end
        end
        if (fired) begin
          hit.idx    = i[2:0];
          hit.status = slots[i].status;
          hits.push_back(hit);
        end
      end
      if (hits.size() > 0) hits[hits.size() - 1].last = 1'b1;
      foreach (hits[k]) due_actions.push_back(hits[k]);
    endfunction

    function void check_action(logic [2:0] idx, logic act, logic [1:0] status, logic lst);
      fired_action_t want;
      if (due_actions.size() == 0) begin
        $error("unexpected result: entry_index=%0d action=%0d new_status=%0d last=%0d",
               idx, act, status, lst);
        errors++;
        return;
      end
      want = due_actions.pop_front();
      checked++;
      if (idx !== want.idx) begin
        $error("entry_index: expected %0d, got %0d", want.idx, idx);
        errors++;
      end
      if (act !== want.act) begin
        $error("action: expected %0d, got %0d", want.act, act);
        errors++;
      end
      if (status !== want.status) begin
        $error("new_status: expected %0d, got %0d", want.status, status);
        errors++;
      end
      if (lst !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, lst);
        errors++;
      end
    endfunction
  endclass

endpackage

module weekday_alarm_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import was_pkg::*;
  import was_tb_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int TARGET_ITEMS = 460;
  localparam int SETTLE       = DEF_ENTRIES + 4;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic       end_action_mask_we;
  logic [7:0] end_action_mask;
  alarm_cmd_t item;
  logic       strobe;
  logic [2:0] entry_index;
  logic       action;
  logic [1:0] new_status;
  logic       last;

  alarm_scoreboard sb;
  int cycles;
  int mask_writes;
  int results_seen;
  int items_sent;
  logic [4:0] pool_hour;
  logic [5:0] pool_min;

  weekday_alarm_scheduler #(.ENTRIES(DEF_ENTRIES)) dut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .end_action_mask_we(end_action_mask_we),
    .end_action_mask   (end_action_mask),
    .cmd               (item.cmd),
    .entry             (item.entry),
    .start_hour        (item.start_hour),
    .start_minute      (item.start_minute),
    .end_hour          (item.end_hour),
    .end_minute        (item.end_minute),
    .weekday_mask      (item.weekday_mask),
    .set_status        (item.set_status),
    .now_hour          (item.now_hour),
    .now_minute        (item.now_minute),
    .now_second        (item.now_second),
    .now_weekday       (item.now_weekday),
    .strobe            (strobe),
    .entry_index       (entry_index),
    .action            (action),
    .new_status        (new_status),
    .last              (last)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (!rst) begin
      if (start && !busy) sb.note_command(item);
      if (end_action_mask_we) sb.set_end_mask(end_action_mask);
      if (strobe) begin
        results_seen++;
        sb.check_action(entry_index, action, new_status, last);
      end
    end
  end

  function automatic alarm_cmd_t prog(logic [2:0] e, logic [4:0] sh, logic [5:0] sm,
                                      logic [4:0] eh, logic [5:0] em, logic [6:0] wm,
                                      logic [1:0] st);
    alarm_cmd_t c;
    c = '0;
    c.cmd          = CMD_PROG;
    c.entry        = e;
    c.start_hour   = sh;
    c.start_minute = sm;
    c.end_hour     = eh;
    c.end_minute   = em;
    c.weekday_mask = wm;
    c.set_status   = st;
    return c;
  endfunction

  function automatic alarm_cmd_t tick(logic [4:0] h, logic [5:0] m, logic [5:0] s,
                                      logic [2:0] wd);
    alarm_cmd_t c;
    c = '0;
    c.cmd         = CMD_TICK;
    c.now_hour    = h;
    c.now_minute  = m;
    c.now_second  = s;
    c.now_weekday = wd;
    return c;
  endfunction

  // Mostly entries clustered around the phase's time pool so ticks hit them.
  function automatic alarm_cmd_t rand_prog();
    alarm_cmd_t c;
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      c = prog(3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
               6'($urandom_range(0, 63)), 5'($urandom_range(0, 31)),
               6'($urandom_range(0, 63)), 7'($urandom_range(0, 127)),
               2'($urandom_range(0, 3)));
    end else begin
      c = prog(3'($urandom_range(0, 7)), pool_hour, 6'(pool_min + $urandom_range(0, 1)),
               pool_hour, 6'(pool_min + $urandom_range(0, 1)),
               ($urandom_range(0, 3) == 0) ? 7'd0 : 7'($urandom_range(1, 127)),
               (r < 8) ? ST_ARMED : ((r == 8) ? ST_RUNNING : ST_OFF));
    end
    // random filler in the tick fields too, so those bits toggle on writes
    c.now_hour    = 5'($urandom_range(0, 31));
    c.now_minute  = 6'($urandom_range(0, 63));
    c.now_second  = 6'($urandom_range(0, 63));
    c.now_weekday = 3'($urandom_range(0, 7));
    return c;
  endfunction

  function automatic alarm_cmd_t rand_tick();
    alarm_cmd_t c;
    if ($urandom_range(0, 9) == 0)
      c = tick(5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)),
               6'($urandom_range(0, 63)), 3'($urandom_range(0, 7)));
    else
      c = tick(pool_hour, 6'(pool_min + $urandom_range(0, 1)), 6'($urandom_range(0, 60)),
               3'($urandom_range(0, 7)));
    c.entry        = 3'($urandom_range(0, 7));
    c.start_hour   = 5'($urandom_range(0, 31));
    c.start_minute = 6'($urandom_range(0, 63));
    c.end_hour     = 5'($urandom_range(0, 31));
    c.end_minute   = 6'($urandom_range(0, 63));
    c.weekday_mask = 7'($urandom_range(0, 127));
    c.set_status   = 2'($urandom_range(0, 3));
    return c;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send(input alarm_cmd_t c);
    start <= 1'b1;
    item  <= c;
    @(negedge clk);
    while (busy) @(negedge clk);
    items_sent++;
  endtask

  task automatic idle(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Hold the sender until every pending action has come and the scan is done.
  task automatic wait_quiet();
    start <= 1'b0;
    while (sb.due_actions.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_end_mask(input logic [7:0] value);
    end_action_mask_we <= 1'b1;
    end_action_mask    <= value;
    @(negedge clk);
    end_action_mask_we <= 1'b0;
    mask_writes++;
  endtask

  initial begin
    int phase;
    logic quiet_sender;
    logic [7:0] mask_val;

    clk                = 1'b0;
    rst                = 1'b1;
    start              = 1'b0;
    end_action_mask_we = 1'b0;
    end_action_mask    = '0;
    item               = '0;
    cycles             = 0;
    mask_writes        = 0;
    results_seen       = 0;
    items_sent         = 0;
    sb = new();

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extremes, both actions, silent run-out, second 30, weekday 7
    write_end_mask(8'hFF);
    send(tick(5'd0, 6'd0, 6'd0, 3'd0));
    send(prog(3'd0, 5'd0, 6'd0, 5'd0, 6'd0, 7'h00, ST_ARMED));
    send(prog(3'd7, 5'd23, 6'd59, 5'd23, 6'd59, 7'h7F, ST_ARMED));
    send(prog(3'd3, 5'd12, 6'd30, 5'd12, 6'd31, 7'h01, ST_UNUSED));
    send(prog(3'd5, 5'd5, 6'd5, 5'd5, 6'd6, 7'h40, ST_RUNNING));
    send(tick(5'd0, 6'd0, 6'd0, 3'd0));
    send(tick(5'd0, 6'd0, 6'd31, 3'd0));
    send(tick(5'd23, 6'd59, 6'd29, 3'd6));
    send(tick(5'd23, 6'd59, 6'd30, 3'd6));
    send(tick(5'd23, 6'd59, 6'd60, 3'd7));
    send(tick(5'd5, 6'd6, 6'd59, 3'd7));
    send(tick(5'd12, 6'd30, 6'd0, 3'd0));
    send(prog(3'd3, 5'd12, 6'd30, 5'd12, 6'd31, 7'h01, ST_ARMED));
    send(tick(5'd12, 6'd30, 6'd0, 3'd7));
    send(tick(5'd31, 6'd63, 6'd63, 3'd7));
    wait_quiet();

    write_end_mask(8'h00);
    send(prog(3'd1, 5'd7, 6'd15, 5'd7, 6'd15, 7'h3E, ST_ARMED));
    send(tick(5'd7, 6'd15, 6'd10, 3'd1));
    send(tick(5'd7, 6'd15, 6'd45, 3'd1));
    send(tick(5'd7, 6'd15, 6'd0, 3'd1));
    send(prog(3'd0, 5'd0, 6'd0, 5'd0, 6'd0, 7'h00, ST_ARMED));
    send(prog(3'd2, 5'd0, 6'd0, 5'd0, 6'd0, 7'h00, ST_ARMED));
    send(prog(3'd4, 5'd0, 6'd0, 5'd0, 6'd0, 7'h00, ST_ARMED));
    send(prog(3'd6, 5'd0, 6'd0, 5'd0, 6'd0, 7'h00, ST_ARMED));
    send(tick(5'd0, 6'd0, 6'd15, 3'd3));
    wait_quiet();

    // random phases, each with its own end-action mask and time pool
    phase = 0;
    while (items_sent < TARGET_ITEMS) begin
      case (phase)
        0: mask_val = 8'h00;
        1: mask_val = 8'hFF;
        2: mask_val = 8'hAA;
        default: mask_val = 8'($urandom_range(0, 255));
      endcase
      write_end_mask(mask_val);
      pool_hour    = 5'($urandom_range(0, 23));
      pool_min     = 6'($urandom_range(0, 58));
      quiet_sender = (phase % 3 == 1);
      repeat (55) begin
        if ($urandom_range(0, 99) < 35) send(rand_prog());
        else send(rand_tick());
        if (!quiet_sender) idle(gap_len());
      end
      wait_quiet();
      phase++;
    end

    start <= 1'b0;
    while (sb.due_actions.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("Ran %0d ticks and %0d entry writes under %0d end-action masks.",
             sb.ticks, sb.progs, mask_writes);
    $display("Checked %0d fired actions, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> sim.f
src/was_pkg.sv
src/was_ram.sv
src/was_ctrl.sv
src/was_dp.sv
src/weekday_alarm_scheduler.sv
verif/weekday_alarm_scheduler_tb.sv
